>>> rtl/core/bdl_pkg.sv
// ----------------------------------------------------------------------------
// bdl_pkg
// Types and codes shared by the bounded deque list and its cell row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdl_pkg;

	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT  = 3'd0,
		OP_PUSH_BACK   = 3'd1,
		OP_INSERT_KEY  = 3'd2,
		OP_POP_FRONT   = 3'd3,
		OP_POP_BACK    = 3'd4,
		OP_DELETE_KEY  = 3'd5,
		OP_CLEAR       = 3'd6,
		OP_DUMP        = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// operation that every cell carries out
	typedef enum logic [3:0] {
		C_HOLD,
		C_SHIFT_BACK,
		C_APPEND,
		C_INSERT,
		C_SHIFT_FRONT,
		C_DROP_BACK,
		C_DELETE,
		C_CLEAR,
		C_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

	// link from a cell to the neighbor behind it
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic                     valid;
		logic                     first;
		logic                     hit;
	} fwd_link_t;

	// link from a cell to the neighbor in front of it
	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic                     valid;
	} bwd_link_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

endpackage

>>> rtl/core/bdl_if.sv
// ----------------------------------------------------------------------------
// bdl_if
// Request and response channels of the bounded deque list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdl_req_if import bdl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;
	logic signed [DATA_W-1:0] key;

	modport source (output valid, output operation, output value, output key, input ready);
	modport sink (input valid, input operation, input value, input key, output ready);
endinterface

interface bdl_rsp_if import bdl_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic [STATUS_W-1:0]      status;
	logic                     last;
	logic [COUNT_W-1:0]       count;

	modport source (output valid, output data, output status, output last, output count,
		input ready);
	modport sink (input valid, input data, input status, input last, input count,
		output ready);
endinterface

>>> rtl/core/bdl_cell.sv
// ----------------------------------------------------------------------------
// bdl_cell
// One list position: holds an entry and its valid bit, compares it with the
// key and moves data to or from its neighbors as the command says.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdl_cell import bdl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_cmd_t                cmd,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] head_data,
	input  fwd_link_t                left,
	input  bwd_link_t                right,
	output fwd_link_t                fwd,
	output bwd_link_t                bwd
);

	logic signed [DATA_W-1:0] data_q;
	logic                     valid_q;
	logic                     match;

	assign match = valid_q && (data_q == key);

	assign fwd.data  = data_q;
	assign fwd.valid = valid_q;
	assign fwd.first = match && !left.hit;
	assign fwd.hit   = left.hit || match;
	assign bwd.data  = data_q;
	assign bwd.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				C_SHIFT_BACK: valid_q <= left.valid;
				C_APPEND: begin
					if (!valid_q && left.valid) valid_q <= 1'b1;
				end
				C_INSERT: begin
					if (left.first) valid_q <= 1'b1;
					else if (left.hit) valid_q <= left.valid;
				end
				C_SHIFT_FRONT: valid_q <= right.valid;
				C_DROP_BACK: valid_q <= valid_q && right.valid;
				C_DELETE: begin
					if (left.hit || match) valid_q <= right.valid;
				end
				C_CLEAR: valid_q <= 1'b0;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			C_SHIFT_BACK: data_q <= left.data;
			C_APPEND: begin
				if (!valid_q && left.valid) data_q <= cmd.value;
			end
			C_INSERT: begin
				if (left.first) data_q <= cmd.value;
				else if (left.hit) data_q <= left.data;
			end
			C_SHIFT_FRONT: data_q <= right.data;
			C_DELETE: begin
				if (left.hit || match) data_q <= right.data;
			end
			// the back entry wraps around to take the head
			C_ROTATE: data_q <= right.valid ? right.data : head_data;
			default: data_q <= data_q;
		endcase
	end

endmodule

>>> rtl/core/bdl_chain.sv
// ----------------------------------------------------------------------------
// bdl_chain
// Row of list cells, front at cell 0, with the neighbor links and the ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdl_chain import bdl_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_cmd_t                cmd,
	input  logic signed [DATA_W-1:0] key,
	output logic signed [DATA_W-1:0] head,
	output logic                     found,
	output logic [DEPTH-1:0]         valid_vec
);

	fwd_link_t fwd [DEPTH+1];
	bwd_link_t bwd [DEPTH+1];

	// front end feeds the new value, back end is an empty slot
	assign fwd[0].data  = cmd.value;
	assign fwd[0].valid = 1'b1;
	assign fwd[0].first = 1'b0;
	assign fwd[0].hit   = 1'b0;
	assign bwd[DEPTH].data  = '0;
	assign bwd[DEPTH].valid = 1'b0;

	assign head  = bwd[0].data;
	assign found = fwd[DEPTH].hit;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bdl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.key       (key),
			.head_data (bwd[0].data),
			.left      (fwd[i]),
			.right     (bwd[i+1]),
			.fwd       (fwd[i+1]),
			.bwd       (bwd[i])
		);
		assign valid_vec[i] = bwd[i].valid;
	end

endmodule

>>> rtl/core/bounded_deque_list.sv
// ----------------------------------------------------------------------------
// bounded_deque_list
// Double-ended queue of up to DEPTH signed 32-bit words in a row of cells.
// Every request except a dump of several entries returns one response with
// last set; push, insert, pop, delete and clear all finish as the request is
// taken because every cell compares with the key and moves its entry at once.
// A dump of n entries returns n responses, one entry per cycle while the
// output register is free, by rotating the row one place per response; no
// request is taken meanwhile. Responses sit in an output register, so a new
// request is taken as soon as that register is empty or being read. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_list import bdl_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bdl_req_if.sink   req,
	bdl_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	state_t                   state_q, state_d;
	logic [CW-1:0]            count_q, count_d;
	logic [CW-1:0]            remain_q, remain_d;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] rsp_data_q;
	status_t                  rsp_status_q;
	logic                     rsp_last_q;
	logic [COUNT_W-1:0]       rsp_count_q;

	cell_cmd_t                cmd;
	logic signed [DATA_W-1:0] head;
	logic                     found;
	logic [DEPTH-1:0]         valid_vec;
	logic                     out_free;
	logic                     req_take;
	logic                     load_out;
	logic signed [DATA_W-1:0] out_data;
	status_t                  out_status;
	logic                     out_last;
	logic                     is_full;
	logic                     is_empty;
	op_t                      op;

	bdl_chain #(.DEPTH(DEPTH)) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key       (req.key),
		.head      (head),
		.found     (found),
		.valid_vec (valid_vec)
	);

	assign op       = op_t'(req.operation);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign req_take = req.valid && req.ready;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		remain_d   = remain_q;
		cmd.op     = C_HOLD;
		cmd.value  = req.value;
		load_out   = 1'b0;
		out_data   = '0;
		out_status = ST_OK;
		out_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (req_take) begin
					load_out = 1'b1;
					unique case (op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (is_full) begin
								out_status = ST_FULL;
							end else begin
								cmd.op  = (op == OP_PUSH_FRONT) ? C_SHIFT_BACK : C_APPEND;
								count_d = count_q + CW'(1);
							end
						end
						OP_INSERT_KEY: begin
							if (is_full) begin
								out_status = ST_FULL;
							end else if (!found) begin
								out_status = ST_NOTFOUND;
							end else begin
								cmd.op  = C_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (is_empty) begin
								out_status = ST_EMPTY;
							end else begin
								cmd.op  = (op == OP_POP_FRONT) ? C_SHIFT_FRONT : C_DROP_BACK;
								count_d = count_q - CW'(1);
							end
						end
						OP_DELETE_KEY: begin
							if (is_empty) begin
								out_status = ST_EMPTY;
							end else if (!found) begin
								out_status = ST_NOTFOUND;
							end else begin
								cmd.op  = C_DELETE;
								count_d = count_q - CW'(1);
							end
						end
						OP_CLEAR: begin
							cmd.op  = C_CLEAR;
							count_d = '0;
						end
						OP_DUMP: begin
							if (is_empty) begin
								out_status = ST_EMPTY;
							end else begin
								// first entry goes out now, the rest in the dump state
								out_data = head;
								out_last = (count_q == CW'(1));
								cmd.op   = C_ROTATE;
								remain_d = count_q - CW'(1);
								if (count_q != CW'(1)) state_d = S_DUMP;
							end
						end
						default: ;
					endcase
				end
			end
			S_DUMP: begin
				if (out_free) begin
					load_out = 1'b1;
					out_data = head;
					out_last = (remain_q == CW'(1));
					cmd.op   = C_ROTATE;
					remain_d = remain_q - CW'(1);
					if (remain_q == CW'(1)) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (load_out) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_data_q   <= out_data;
			rsp_status_q <= out_status;
			rsp_last_q   <= out_last;
			rsp_count_q  <= COUNT_W'(count_d);
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.status = rsp_status_q;
	assign rsp.last   = rsp_last_q;
	assign rsp.count  = rsp_count_q;

	// cell valid bits always agree with the entry count
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_no_request_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !req.ready)
		else $error("request taken during dump");

	a_dump_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(req_take && (op == OP_DUMP) && (count_q > CW'(1))) |=> (state_q == S_DUMP))
		else $error("dump of several entries did not start streaming");

	a_dump_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> $stable(count_q))
		else $error("entry count changed during dump");

endmodule
